/* src/sal_pkg.sv */
// Shared constants, codes and controller/datapath command types for the array list unit.
package sal_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OP_W     = 3;
  localparam int POS_W    = 9;
  localparam int VAL_W    = 32;
  localparam int ST_W     = 3;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_READ   = 3'd2,
    OP_LOCATE = 3'd3,
    OP_PRED   = 3'd4,
    OP_SUCC   = 3'd5,
    OP_CLEAR  = 3'd6
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_NONEIGH  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_COUNT,
    IDX_POS,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  typedef enum logic [1:0] {
    ADDR_AT,
    ADDR_BELOW,
    ADDR_ABOVE
  } addr_sel_t;

  typedef enum logic {
    WD_RDATA,
    WD_VALUE
  } wd_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_ZERO
  } cnt_op_t;

  typedef enum logic [1:0] {
    RV_HOLD,
    RV_RDATA,
    RV_PREV
  } rv_op_t;

  typedef struct packed {
    logic      load_req;
    idx_op_t   idx_op;
    logic      rd_en;
    addr_sel_t rd_sel;
    logic      wr_en;
    addr_sel_t wr_sel;
    wd_sel_t   wr_data;
    cnt_op_t   cnt_op;
    logic      prev_we;
    logic      st_we;
    status_t   st_code;
    rv_op_t    rv_op;
    logic      pos_we;
    logic      load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            ins_pos_ok;
    logic            acc_pos_ok;
    logic            full;
    logic            idx_ge_pos;
    logic            idx_lt_count;
    logic            idx_zero;
    logic            idx_last;
    logic            match;
    logic            out_free;
  } dp_sts_t;

endpackage

/* src/sal_req_if.sv */
// Request channel: operation, position and value with a valid/ready handshake.
interface sal_req_if;
  import sal_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output op, output position, output value, input ready);
  modport sink   (input valid, input op, input position, input value, output ready);
endinterface

/* src/sal_rsp_if.sv */
// Response channel: result value, position, status and length with a valid/ready handshake.
interface sal_rsp_if;
  import sal_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] out_value;
  logic [POS_W-1:0]        out_position;
  logic [ST_W-1:0]         status;
  logic [POS_W-1:0]        list_length;

  modport source (output valid, output out_value, output out_position, output status,
                  output list_length, input ready);
  modport sink   (input valid, input out_value, input out_position, input status,
                  input list_length, output ready);
endinterface

/* src/sequential_array_list_unit.sv */
// Top level of the array list unit: request/response channels around controller and datapath.
//
//   Channel | Modport | Payload                                          | Transfer when
//   --------+---------+--------------------------------------------------+----------------------
//   req     | sink    | op, position, value                              | req.valid & req.ready
//   rsp     | source  | out_value, out_position, status, list_length     | rsp.valid & rsp.ready
//
// One request is in work at a time. Its time grows with each store entry it touches: an
// insert moves the entries from the insert slot to the end, a delete those after the
// slot, and a search reads entries up to the first match, so a delete at position 1 or
// a failed search in a full list takes longest. The store has one write port and one
// registered read port, never used together: a shift step is one read then one write.
// Reset (synchronous, active high) empties the list and drops any pending result; the
// store contents are left as they are, since only entries below the count are ever read.
// A finished result waits in the output register while the next request is taken; a
// second finished result waits in the controller until the first transfer completes.
module sequential_array_list_unit (
  input  logic      clk,
  input  logic      rst,
  sal_req_if.sink   req,
  sal_rsp_if.source rsp
);
  import sal_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // The controller decides which step runs each cycle; it never sees position or value
  // data, only the operation code and the compare and status bits that the datapath reports.
  sal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the list store, the element count, the scan index and both the
  // working result and the output register that feeds the response channel.
  sal_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_op        (req.op),
    .in_position  (req.position),
    .in_value     (req.value),
    .out_ready    (rsp.ready),
    .out_valid    (rsp.valid),
    .out_value    (rsp.out_value),
    .out_position (rsp.out_position),
    .out_status   (rsp.status),
    .out_length   (rsp.list_length)
  );

endmodule

/* src/sal_dp.sv */
// Datapath of the array list unit: list store, count, scan index and result registers.
module sal_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  sal_pkg::dp_cmd_t                 cmd,
  output sal_pkg::dp_sts_t                 sts,
  input  logic [sal_pkg::OP_W-1:0]         in_op,
  input  logic [sal_pkg::POS_W-1:0]        in_position,
  input  logic signed [sal_pkg::VAL_W-1:0] in_value,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic signed [sal_pkg::VAL_W-1:0] out_value,
  output logic [sal_pkg::POS_W-1:0]        out_position,
  output logic [sal_pkg::ST_W-1:0]         out_status,
  output logic [sal_pkg::POS_W-1:0]        out_length
);
  import sal_pkg::*;

  localparam int CMP_W = POS_W + 1;

  logic [VAL_W-1:0] store [CAPACITY];
  logic [VAL_W-1:0] rdata;
  logic [VAL_W-1:0] prev;

  logic [OP_W-1:0]  op_q;
  logic [POS_W-1:0] pos_q;
  logic [VAL_W-1:0] val_q;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;

  logic [VAL_W-1:0] res_value;
  logic [POS_W-1:0] res_pos;
  status_t          res_status;

  logic [CNT_W-1:0] rd_full;
  logic [CNT_W-1:0] wr_full;
  logic [VAL_W-1:0] wr_word;
  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] pos_ext;
  logic [CNT_W:0]   idx_p1;

  function automatic logic [CNT_W-1:0] addr_calc(logic [CNT_W-1:0] base, addr_sel_t sel);
    logic [CNT_W-1:0] a;
    case (sel)
      ADDR_BELOW: a = base - CNT_W'(1);
      ADDR_ABOVE: a = base + CNT_W'(1);
      default:    a = base;
    endcase
    return a;
  endfunction

  always_comb begin
    rd_full = addr_calc(idx, cmd.rd_sel);
    wr_full = addr_calc(idx, cmd.wr_sel);
    wr_word = (cmd.wr_data == WD_VALUE) ? val_q : rdata;
    cnt_ext = CMP_W'(count);
    pos_ext = CMP_W'(pos_q);
    idx_p1  = (CNT_W + 1)'(idx) + (CNT_W + 1)'(1);
  end

  always_comb begin
    sts.op           = op_q;
    sts.ins_pos_ok   = (pos_q != '0) && (pos_ext <= cnt_ext + CMP_W'(1));
    sts.acc_pos_ok   = (pos_q != '0) && (pos_ext <= cnt_ext);
    sts.full         = (count >= CNT_W'(CAPACITY));
    sts.idx_ge_pos   = (CMP_W'(idx) >= pos_ext);
    sts.idx_lt_count = (idx < count);
    sts.idx_zero     = (idx == '0);
    sts.idx_last     = (idx_p1 >= (CNT_W + 1)'(count));
    sts.match        = (rdata == val_q);
    sts.out_free     = !out_valid || out_ready;
  end

  // List store: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      store[wr_full[IDX_W-1:0]] <= wr_word;
    end
    if (cmd.rd_en) begin
      rdata <= store[rd_full[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_q  <= in_op;
      pos_q <= in_position;
      val_q <= in_value;
    end
    if (cmd.prev_we) begin
      prev <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      res_value  <= '0;
      res_pos    <= '0;
      res_status <= ST_OK;
    end else begin
      if (cmd.st_we) begin
        res_status <= cmd.st_code;
      end
      case (cmd.rv_op)
        RV_RDATA: res_value <= rdata;
        RV_PREV:  res_value <= prev;
        default:  res_value <= res_value;
      endcase
      if (cmd.pos_we) begin
        res_pos <= POS_W'(idx) + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx   <= '0;
    end else begin
      case (cmd.cnt_op)
        CNT_INC:  count <= count + CNT_W'(1);
        CNT_DEC:  count <= count - CNT_W'(1);
        CNT_ZERO: count <= '0;
        default:  count <= count;
      endcase
      case (cmd.idx_op)
        IDX_ZERO:  idx <= '0;
        IDX_COUNT: idx <= count;
        IDX_POS:   idx <= CNT_W'(pos_q);
        IDX_INC:   idx <= idx + CNT_W'(1);
        IDX_DEC:   idx <= idx - CNT_W'(1);
        default:   idx <= idx;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_value    <= res_value;
      out_position <= res_pos;
      out_status   <= res_status;
      out_length   <= POS_W'(count);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("element count exceeds capacity");

  a_write_in_list: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> wr_full <= count)
    else $error("store write beyond the end of the list");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_op == CNT_HOLD |=> $stable(count))
    else $error("element count changed without a command");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("loaded result not presented");

endmodule

/* src/sal_ctrl.sv */
// Controller of the array list unit: sequences shifts, scans and result hand-off.
module sal_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  sal_pkg::dp_sts_t sts,
  output sal_pkg::dp_cmd_t cmd
);
  import sal_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_CHK,
    S_INS_WR,
    S_ACC_RD,
    S_ACC_CAP,
    S_DEL_CHK,
    S_DEL_WR,
    S_SCAN_CHK,
    S_SCAN_CMP,
    S_SUCC_CAP,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_DONE;
        case (sts.op)
          OP_INSERT: begin
            if (!sts.ins_pos_ok) begin
              cmd.st_we   = 1'b1;
              cmd.st_code = ST_BADPOS;
            end else if (sts.full) begin
              cmd.st_we   = 1'b1;
              cmd.st_code = ST_FULL;
            end else begin
              cmd.idx_op = IDX_COUNT;
              state_next = S_INS_CHK;
            end
          end
          OP_DELETE, OP_READ: begin
            if (!sts.acc_pos_ok) begin
              cmd.st_we   = 1'b1;
              cmd.st_code = ST_BADPOS;
            end else begin
              cmd.idx_op = IDX_POS;
              state_next = S_ACC_RD;
            end
          end
          OP_LOCATE, OP_PRED, OP_SUCC: begin
            cmd.idx_op = IDX_ZERO;
            state_next = S_SCAN_CHK;
          end
          OP_CLEAR: begin
            cmd.cnt_op = CNT_ZERO;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      // Shift entries up from the end until the index reaches the insert slot.
      S_INS_CHK: begin
        if (sts.idx_ge_pos) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ADDR_BELOW;
          state_next = S_INS_WR;
        end else begin
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = ADDR_AT;
          cmd.wr_data = WD_VALUE;
          cmd.cnt_op  = CNT_INC;
          state_next  = S_DONE;
        end
      end
      S_INS_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = ADDR_AT;
        cmd.wr_data = WD_RDATA;
        cmd.idx_op  = IDX_DEC;
        state_next  = S_INS_CHK;
      end
      S_ACC_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ADDR_BELOW;
        state_next = S_ACC_CAP;
      end
      S_ACC_CAP: begin
        cmd.rv_op  = RV_RDATA;
        state_next = (sts.op == OP_READ) ? S_DONE : S_DEL_CHK;
      end
      // Shift the entries after the deleted one down by one slot.
      S_DEL_CHK: begin
        if (sts.idx_lt_count) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ADDR_AT;
          state_next = S_DEL_WR;
        end else begin
          cmd.cnt_op = CNT_DEC;
          state_next = S_DONE;
        end
      end
      S_DEL_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = ADDR_BELOW;
        cmd.wr_data = WD_RDATA;
        cmd.idx_op  = IDX_INC;
        state_next  = S_DEL_CHK;
      end
      S_SCAN_CHK: begin
        if (sts.idx_lt_count) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ADDR_AT;
          state_next = S_SCAN_CMP;
        end else begin
          cmd.st_we   = 1'b1;
          cmd.st_code = ST_NOTFOUND;
          state_next  = S_DONE;
        end
      end
      S_SCAN_CMP: begin
        if (sts.match) begin
          state_next = S_DONE;
          case (sts.op)
            OP_LOCATE: begin
              cmd.pos_we = 1'b1;
            end
            OP_PRED: begin
              if (sts.idx_zero) begin
                cmd.st_we   = 1'b1;
                cmd.st_code = ST_NONEIGH;
              end else begin
                cmd.rv_op = RV_PREV;
              end
            end
            default: begin
              if (sts.idx_last) begin
                cmd.st_we   = 1'b1;
                cmd.st_code = ST_NONEIGH;
              end else begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = ADDR_ABOVE;
                state_next = S_SUCC_CAP;
              end
            end
          endcase
        end else begin
          cmd.prev_we = 1'b1;
          cmd.idx_op  = IDX_INC;
          state_next  = S_SCAN_CHK;
        end
      end
      S_SUCC_CAP: begin
        cmd.rv_op  = RV_RDATA;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load_req |=> !req_ready)
    else $error("request taken while a request is in progress");

  a_load_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded over an untaken result");

  a_port_conflict: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> !cmd.rd_en && !cmd.load_req)
    else $error("store read and write issued together");

endmodule

/* bench/tb.sv */
// Self-checking testbench for the array list unit: directed and random list requests.
`timescale 1ns / 1ps

module tb;
  import sal_pkg::*;

  // The op field is three bits wide, so code 7 can be sent even though the block
  // defines no operation for it. The block must answer it without touching the list.
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  // After the last expected result has arrived we wait longer than the worst-case
  // request time to catch stray results.
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 10;

  // Everything we expect to see for one request.
  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
    status_t                 status;
    logic [POS_W-1:0]        length;
  } list_result_t;

  logic clk;
  logic rst;

  sal_req_if req_ch ();
  sal_rsp_if rsp_ch ();

  sequential_array_list_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Our own copy of the list. It is updated when a request transfer is seen, so the
  // expected result of each request is computed against the list exactly as the block
  // holds it at that moment.
  logic signed [VAL_W-1:0] model_store [CAPACITY];
  int                      model_count;

  // Results we are still waiting for, oldest first.
  list_result_t pending_results [$];

  int error_count;

  // While this is set, both sides of the block idle in random bursts.
  bit idle_bursts_on;

  // Free-running clock with a 4 ns period.
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // A generous fixed limit. A correct run needs well under a tenth of this.
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Index of the first entry equal to val, or -1 when the value is not in the list.
  function automatic int find_first_match(input logic signed [VAL_W-1:0] val);
    for (int i = 0; i < model_count; i++) begin
      if (model_store[i] == val) return i;
    end
    return -1;
  endfunction

  // Applies one request to our copy of the list and returns the result the block
  // must produce for it.
  function automatic list_result_t predict_list_op(input logic [OP_W-1:0] op,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic signed [VAL_W-1:0] val);
    list_result_t res;
    int           p;
    int           k;
    res.value    = '0;
    res.position = '0;
    res.status   = ST_OK;
    p = int'(pos);
    case (op)
      OP_INSERT: begin
        // The position check comes before the fullness check.
        if (p < 1 || p > model_count + 1) begin
          res.status = ST_BADPOS;
        end else if (model_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          for (int i = model_count; i >= p; i--) model_store[i] = model_store[i - 1];
          model_store[p - 1] = val;
          model_count++;
        end
      end
      OP_DELETE: begin
        if (p < 1 || p > model_count) begin
          res.status = ST_BADPOS;
        end else begin
          res.value = model_store[p - 1];
          for (int i = p; i < model_count; i++) model_store[i - 1] = model_store[i];
          model_count--;
        end
      end
      OP_READ: begin
        if (p < 1 || p > model_count) res.status = ST_BADPOS;
        else res.value = model_store[p - 1];
      end
      OP_LOCATE: begin
        k = find_first_match(val);
        if (k < 0) res.status = ST_NOTFOUND;
        else res.position = POS_W'(k + 1);
      end
      OP_PRED: begin
        k = find_first_match(val);
        if (k < 0) res.status = ST_NOTFOUND;
        else if (k == 0) res.status = ST_NONEIGH;
        else res.value = model_store[k - 1];
      end
      OP_SUCC: begin
        k = find_first_match(val);
        if (k < 0) res.status = ST_NOTFOUND;
        else if (k + 1 >= model_count) res.status = ST_NONEIGH;
        else res.value = model_store[k + 1];
      end
      OP_CLEAR: begin
        model_count = 0;
      end
      default: begin
        // The unused code leaves the list alone and reports zeros.
      end
    endcase
    res.length = POS_W'(model_count);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Sends one request and returns at the clock edge of its transfer. Valid stays high
  // afterwards, so back-to-back requests need no dead cycle; the next call either
  // loads new payload or drops valid for an idle burst.
  task automatic issue_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                               input logic signed [VAL_W-1:0] val);
    if (idle_bursts_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.op       <= op;
    req_ch.position <= pos;
    req_ch.value    <= val;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_results.push_back(predict_list_op(op, pos, val));
  endtask

  // Holds the request side idle until every expected result has come back, then lets
  // the block settle for the worst-case request time.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Response side
  // ---------------------------------------------------------------------------

  // Ready is high by default and drops in random bursts while idling is enabled.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_bursts_on && $urandom_range(0, 7) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
    end
  end

  task automatic report_error(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // Every result transfer is compared field by field against the oldest expectation.
  // Outputs are sampled at the edge, before any update scheduled at that same edge.
  always @(posedge clk) begin : check_results
    list_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_error($sformatf("result with none expected (status %0d, length %0d)",
                               rsp_ch.status, rsp_ch.list_length));
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.out_value !== want.value)
          report_error($sformatf("out_value got %0d expected %0d",
                                 rsp_ch.out_value, want.value));
        if (rsp_ch.out_position !== want.position)
          report_error($sformatf("out_position got %0d expected %0d",
                                 rsp_ch.out_position, want.position));
        if (rsp_ch.status !== want.status)
          report_error($sformatf("status got %0d expected %0d",
                                 rsp_ch.status, want.status));
        if (rsp_ch.list_length !== want.length)
          report_error($sformatf("list_length got %0d expected %0d",
                                 rsp_ch.list_length, want.length));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus choices
  // ---------------------------------------------------------------------------

  // A handful of values that show up often, so the list holds duplicates and the
  // searches see repeated first matches.
  function automatic logic signed [VAL_W-1:0] pool_value();
    case ($urandom_range(0, 5))
      0:       return 32'sd0;
      1:       return -32'sd1;
      2:       return 32'sd1;
      3:       return 32'sh8000_0000;
      4:       return 32'sh7fff_ffff;
      default: return 32'sh5a5a_5a5a;
    endcase
  endfunction

  // Searches mostly look for a value that is in the list; inserts mix pool values
  // with fully random ones so every value bit takes both levels.
  function automatic logic signed [VAL_W-1:0] pick_value(input logic [OP_W-1:0] op);
    int r;
    r = $urandom_range(0, 99);
    if ((op == OP_LOCATE || op == OP_PRED || op == OP_SUCC) && model_count > 0 && r < 55)
      return model_store[$urandom_range(0, model_count - 1)];
    if (r < 80 && r >= 40) return pool_value();
    return $urandom;
  endfunction

  // Mostly a legal position, with the edges just outside the list and the whole
  // nine-bit field mixed in.
  function automatic logic [POS_W-1:0] pick_position(input logic [OP_W-1:0] op);
    int lim;
    int r;
    lim = (op == OP_INSERT) ? model_count + 1 : model_count;
    r = $urandom_range(0, 99);
    if (r < 8) return POS_W'($urandom_range(0, 511));
    if (r < 14) return POS_W'(lim + 1);
    if (r < 17) return '0;
    if (lim == 0) return POS_W'(1);
    return POS_W'($urandom_range(1, lim));
  endfunction

  // Inserts dominate so the list fills up; near capacity deletes take over. Clears
  // empty it now and then, so the run passes through all lengths.
  function automatic logic [OP_W-1:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return OP_UNUSED;
    if (r < 5) return OP_CLEAR;
    if (r < 35) begin
      if (model_count >= CAPACITY - 1 && r < 25) return OP_DELETE;
      return OP_INSERT;
    end
    if (r < 50) return OP_DELETE;
    if (r < 63) return OP_READ;
    if (r < 76) return OP_LOCATE;
    if (r < 88) return OP_PRED;
    return OP_SUCC;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every operation on an empty list: all of them but the clear must fail cleanly.
  task automatic test_empty_list();
    issue_request(OP_READ,   9'd1, 32'sd0);
    issue_request(OP_DELETE, 9'd1, 32'sd0);
    issue_request(OP_LOCATE, 9'd0, 32'sd0);
    issue_request(OP_PRED,   9'd0, 32'sd0);
    issue_request(OP_SUCC,   9'd0, 32'sd0);
    issue_request(OP_INSERT, 9'd0, 32'sd7);
    issue_request(OP_INSERT, 9'd2, 32'sd7);
    issue_request(OP_CLEAR,  9'd0, 32'sd0);
  endtask

  // A short hand-built list that exercises shifts, the value extremes, the neighbour
  // edge cases and the unused code.
  task automatic test_basic_ops();
    issue_request(OP_INSERT, 9'd1, 32'sh8000_0000);
    issue_request(OP_INSERT, 9'd2, 32'sh7fff_ffff);
    issue_request(OP_INSERT, 9'd1, 32'sd0);          // shifts both entries up
    issue_request(OP_INSERT, 9'd4, -32'sd1);         // append at count + 1
    issue_request(OP_INSERT, 9'd511, 32'sd3);        // far past the end
    issue_request(OP_READ,   9'd4, 32'sd0);
    issue_request(OP_READ,   9'd5, 32'sd0);          // one past the end
    issue_request(OP_READ,   9'd511, 32'sd0);
    issue_request(OP_LOCATE, 9'd0, 32'sh7fff_ffff);
    issue_request(OP_LOCATE, 9'd0, 32'sd12345);      // absent
    issue_request(OP_PRED,   9'd0, 32'sd0);          // first entry has no predecessor
    issue_request(OP_PRED,   9'd0, 32'sh7fff_ffff);
    issue_request(OP_SUCC,   9'd0, -32'sd1);         // last entry has no successor
    issue_request(OP_SUCC,   9'd0, 32'sd0);
    issue_request(OP_DELETE, 9'd2, 32'sd0);          // shifts the tail down
    issue_request(OP_DELETE, 9'd3, 32'sd0);          // removes the last entry
    issue_request(OP_UNUSED, 9'd511, 32'shffff_ffff);
    issue_request(OP_CLEAR,  9'd0, 32'sd0);
  endtask

  // Fills the list to capacity at random positions, checks the full and bad-position
  // cases there, then drains it again with deletes at random positions.
  task automatic test_fill_to_capacity();
    issue_request(OP_CLEAR, 9'd0, 32'sd0);
    for (int k = 0; k < CAPACITY; k++)
      issue_request(OP_INSERT, POS_W'($urandom_range(1, k + 1)), pick_value(OP_INSERT));
    issue_request(OP_INSERT, POS_W'($urandom_range(1, CAPACITY + 1)), $urandom);
    // At capacity a position past count + 1 is still reported as a bad position.
    issue_request(OP_INSERT, POS_W'(CAPACITY + 2), $urandom);
    issue_request(OP_READ, POS_W'(CAPACITY), 32'sd0);
    issue_request(OP_LOCATE, 9'd0, model_store[CAPACITY - 1]);
    issue_request(OP_SUCC, 9'd0, model_store[CAPACITY - 1]);
    issue_request(OP_PRED, 9'd0, model_store[CAPACITY - 1]);
    for (int k = 0; k < CAPACITY; k++)
      issue_request(OP_DELETE, POS_W'($urandom_range(1, CAPACITY - k)), 32'sd0);
    issue_request(OP_DELETE, 9'd1, 32'sd0);
  endtask

  task automatic test_random_ops(input int n_items);
    logic [OP_W-1:0]         op;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
    for (int k = 0; k < n_items; k++) begin
      op  = pick_op();
      pos = pick_position(op);
      val = pick_value(op);
      issue_request(op, pos, val);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------

  initial begin
    error_count     = 0;
    model_count     = 0;
    idle_bursts_on  = 1'b0;
    for (int i = 0; i < CAPACITY; i++) model_store[i] = '0;
    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.op       <= OP_INSERT;
    req_ch.position <= '0;
    req_ch.value    <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part, first without idling so requests arrive back to back.
    test_empty_list();
    test_basic_ops();
    wait_drained();

    // Random part with idle bursts on both sides. The pause in the middle lets the
    // block go fully idle before traffic resumes.
    idle_bursts_on = 1'b1;
    test_fill_to_capacity();
    test_random_ops(250);
    wait_drained();
    test_random_ops(250);

    // The last stretch runs at full rate on both sides.
    idle_bursts_on = 1'b0;
    test_random_ops(40);

    wait_drained();
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
